// ----- hw/rtl/ils_pkg.sv -----
// Shared types, codes and sizes for the indexed list store.
package ils_pkg;

    // Store geometry
    localparam int DEPTH   = 64;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Action codes carried by each input item
    localparam logic [3:0] ACT_APPEND    = 4'd0;
    localparam logic [3:0] ACT_INSERT    = 4'd1;
    localparam logic [3:0] ACT_READ      = 4'd2;
    localparam logic [3:0] ACT_OVERWRITE = 4'd3;
    localparam logic [3:0] ACT_REMOVE    = 4'd4;
    localparam logic [3:0] ACT_POP       = 4'd5;
    localparam logic [3:0] ACT_FIND      = 4'd6;
    localparam logic [3:0] ACT_CONTAINS  = 4'd7;
    localparam logic [3:0] ACT_CLEAR     = 4'd8;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // What each cell does with its entry this cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    // Command broadcast to the whole row of cells
    typedef struct packed {
        cell_op_t           op;
        logic               sample;
        logic [CNT_W-1:0]   pos;
        logic [CNT_W-1:0]   count;
        logic [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

// ----- hw/rtl/ils_cell.sv -----
// One storage cell of the list: holds an entry, shifts with its neighbors, compares.
module ils_cell
    import ils_pkg::*;
(
    input  logic               aclk,
    input  logic [IDX_W-1:0]   cell_idx,
    input  cell_cmd_t          cmd,
    input  logic [VALUE_W-1:0] left_data,
    input  logic [VALUE_W-1:0] right_data,
    output logic [VALUE_W-1:0] entry_data,
    output logic               match,
    output logic [VALUE_W-1:0] read_data
);

    logic [VALUE_W-1:0] entry_reg, entry_next;
    logic               match_reg;
    logic [VALUE_W-1:0] read_reg;
    logic [CNT_W-1:0]   idx_ext;
    logic               at_pos;

    assign idx_ext = CNT_W'(cell_idx);
    assign at_pos  = (idx_ext == cmd.pos);

    // Next entry: take from a neighbor on a shift, the item value on a write
    always_comb begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CELL_INSERT: begin
                if (idx_ext > cmd.pos) begin
                    entry_next = left_data;
                end else if (at_pos) begin
                    entry_next = cmd.value;
                end
            end
            CELL_REMOVE: begin
                if (idx_ext >= cmd.pos) begin
                    entry_next = right_data;
                end
            end
            CELL_WRITE: begin
                if (at_pos) begin
                    entry_next = cmd.value;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Entry, plus compare and read taken from the contents before the update
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (cmd.sample) begin
            match_reg <= (idx_ext < cmd.count) && (entry_reg == cmd.value);
            read_reg  <= at_pos ? entry_reg : '0;
        end
    end

    assign entry_data = entry_reg;
    assign match      = match_reg;
    assign read_data  = read_reg;

endmodule

// ----- hw/rtl/ils_collect.sv -----
// Gathers the row's compare and read outputs: first match position and read value.
module ils_collect
    import ils_pkg::*;
(
    input  logic [DEPTH-1:0]               match_vec,
    input  logic [DEPTH-1:0][VALUE_W-1:0]  read_vec,
    output logic                           any_match,
    output logic [IDX_W-1:0]               first_idx,
    output logic [VALUE_W-1:0]             read_or
);

    // Lowest matching cell wins
    always_comb begin
        first_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    // At most one cell presents nonzero read data
    always_comb begin
        read_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            read_or = read_or | read_vec[i];
        end
    end

    assign any_match = |match_vec;

endmodule

// ----- hw/rtl/indexed_list_store.sv -----
// Top level of the indexed list store: control, entry count and result register.
//
//  channel | direction | ports                                    | accepted when
//  --------+-----------+------------------------------------------+------------------
//  s_      | in        | action, position, item_value             | s_valid & s_ready
//  m_      | out       | status, read_value, found_position,      | m_valid & m_ready
//          |           | found, count, empty_res                  |
//
// Each item passes through S_BUSY, in which the cell row shifts or writes and samples its
// compares and read data, then S_RESP, in which the collect logic forms the result into the
// output register. The next item is taken in S_RESP, as that result is loaded, and not
// before. Reset clears the count and control; entries are not cleared.
// While a finished result waits at the output, one more item is taken and executed,
// then the block holds it until the output register frees.
module indexed_list_store
    import ils_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_action,
    input  logic [CNT_W-1:0]   s_position,
    input  logic [VALUE_W-1:0] s_item_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [VALUE_W-1:0] m_read_value,
    output logic [IDX_W-1:0]   m_found_position,
    output logic               m_found,
    output logic [CNT_W-1:0]   m_count,
    output logic               m_empty_res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         act_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         pre_status_reg, pre_status_next;
    logic               rd_en_reg, rd_en_next;

    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic [VALUE_W-1:0] m_read_value_reg;
    logic [IDX_W-1:0]   m_found_position_reg;
    logic               m_found_reg;
    logic [CNT_W-1:0]   m_count_reg;

    cell_cmd_t          cmd;
    logic               out_free, accept, load_out, is_search;
    logic               any_match;
    logic [IDX_W-1:0]   first_idx;
    logic [VALUE_W-1:0] read_or;

    logic [DEPTH-1:0][VALUE_W-1:0] cell_data;
    logic [DEPTH-1:0][VALUE_W-1:0] cell_read;
    logic [DEPTH-1:0]              cell_match;

    // Handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) || ((state_reg == S_RESP) && out_free);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == S_RESP) && out_free;
    assign is_search = (act_reg == ACT_FIND) || (act_reg == ACT_CONTAINS);

    // Decode the held item into a row command, new count and early status
    always_comb begin
        cmd.op          = CELL_HOLD;
        cmd.sample      = (state_reg == S_BUSY);
        cmd.pos         = pos_reg;
        cmd.count       = count_reg;
        cmd.value       = val_reg;
        count_next      = count_reg;
        pre_status_next = ST_OK;
        rd_en_next      = 1'b0;
        if (state_reg == S_BUSY) begin
            unique case (act_reg)
                ACT_APPEND, ACT_INSERT: begin
                    if ((act_reg == ACT_INSERT) && (pos_reg > count_reg)) begin
                        pre_status_next = ST_RANGE;
                    end else if (count_reg >= CNT_W'(DEPTH)) begin
                        pre_status_next = ST_FULL;
                    end else begin
                        cmd.op     = CELL_INSERT;
                        cmd.pos    = (act_reg == ACT_APPEND) ? count_reg : pos_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_READ, ACT_OVERWRITE, ACT_REMOVE, ACT_POP: begin
                    if (pos_reg >= count_reg) begin
                        pre_status_next = ST_RANGE;
                    end else begin
                        rd_en_next = (act_reg == ACT_READ) || (act_reg == ACT_POP);
                        if (act_reg == ACT_OVERWRITE) begin
                            cmd.op = CELL_WRITE;
                        end else if ((act_reg == ACT_REMOVE) || (act_reg == ACT_POP)) begin
                            cmd.op     = CELL_REMOVE;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                ACT_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Row of cells, each fed by both neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_W-1:0] left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_right
            assign right_d = cell_data[i+1];
        end
        ils_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .entry_data (cell_data[i]),
            .match      (cell_match[i]),
            .read_data  (cell_read[i])
        );
    end

    ils_collect u_collect (
        .match_vec (cell_match),
        .read_vec  (cell_read),
        .any_match (any_match),
        .first_idx (first_idx),
        .read_or   (read_or)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (load_out) begin
                    state_next = accept ? S_BUSY : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= s_action;
            pos_reg <= s_position;
            val_reg <= s_item_value;
        end
        if (state_reg == S_BUSY) begin
            pre_status_reg <= pre_status_next;
            rd_en_reg      <= rd_en_next;
        end
        if (load_out) begin
            m_read_value_reg     <= rd_en_reg ? read_or : '0;
            m_found_reg          <= is_search && any_match;
            m_found_position_reg <= (is_search && any_match) ? first_idx : '0;
            m_count_reg          <= count_reg;
            if (is_search) begin
                m_status_reg <= (!any_match && (act_reg == ACT_FIND)) ? ST_NOT_FOUND : ST_OK;
            end else begin
                m_status_reg <= pre_status_reg;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_read_value     = m_read_value_reg;
    assign m_found_position = m_found_position_reg;
    assign m_found          = m_found_reg;
    assign m_count          = m_count_reg;
    assign m_empty_res      = (m_count_reg == '0);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above store depth");

    a_busy_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BUSY) |=> (state_reg == S_RESP))
        else $error("execute cycle not followed by response");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid)
        else $error("result not presented after load");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_status == ST_OK))
        else $error("found item with non-ok status");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BUSY) |-> !s_ready)
        else $error("item taken during execute cycle");
`endif

endmodule

// ----- dv/tb_indexed_list_store.sv -----
// Self-checking testbench for the indexed list store: directed, full-store, stall and random traffic.
module tb_indexed_list_store;
    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;

    localparam int IDLE_LIMIT   = 3000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_SIZE    = 16;

    // One result item, fields in port order
    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] read_value;
        logic [IDX_W-1:0]   found_position;
        logic               found;
        logic [CNT_W-1:0]   count;
        logic               empty_res;
    } list_result_t;

    // Receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_EVERY_THIRD
    } rx_pattern_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [3:0]         s_action;
    logic [CNT_W-1:0]   s_position;
    logic [VALUE_W-1:0] s_item_value;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [VALUE_W-1:0] m_read_value;
    logic [IDX_W-1:0]   m_found_position;
    logic               m_found;
    logic [CNT_W-1:0]   m_count;
    logic               m_empty_res;

    // Shadow copy of the store
    logic [VALUE_W-1:0] shadow_entries [DEPTH];
    int                 shadow_count;

    list_result_t       pending_results [$];
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];
    int                 mismatch_count;
    int                 burst_left;
    logic               hold_request;
    int                 idle_cycles;

    rx_pattern_t        rx_pattern;
    int                 rx_left;
    int                 hold_left;
    int                 rx_phase;

    indexed_list_store dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_position       (s_position),
        .s_item_value     (s_item_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_read_value     (m_read_value),
        .m_found_position (m_found_position),
        .m_found          (m_found),
        .m_count          (m_count),
        .m_empty_res      (m_empty_res)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Apply one action to the shadow store and return the result it should give
    function automatic list_result_t apply_action(input logic [3:0] act,
                                                  input logic [CNT_W-1:0] pos,
                                                  input logic [VALUE_W-1:0] val);
        list_result_t r;
        int           p;
        int           i;
        r = '0;
        case (act)
            ACT_APPEND, ACT_INSERT: begin
                if (act == ACT_INSERT && int'(pos) > shadow_count) begin
                    r.status = ST_RANGE;
                end else if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    p = (act == ACT_APPEND) ? shadow_count : int'(pos);
                    for (i = shadow_count; i > p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p] = val;
                    shadow_count++;
                end
            end
            ACT_READ, ACT_OVERWRITE, ACT_REMOVE, ACT_POP: begin
                if (int'(pos) >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    p = int'(pos);
                    if (act == ACT_READ || act == ACT_POP)
                        r.read_value = shadow_entries[p];
                    if (act == ACT_OVERWRITE)
                        shadow_entries[p] = val;
                    if (act == ACT_REMOVE || act == ACT_POP) begin
                        for (i = p; i + 1 < shadow_count; i++)
                            shadow_entries[i] = shadow_entries[i+1];
                        shadow_count--;
                    end
                end
            end
            ACT_FIND, ACT_CONTAINS: begin
                for (i = 0; i < shadow_count; i++) begin
                    if (!r.found && shadow_entries[i] == val) begin
                        r.found          = 1'b1;
                        r.found_position = i[IDX_W-1:0];
                    end
                end
                if (!r.found && act == ACT_FIND)
                    r.status = ST_NOT_FOUND;
            end
            ACT_CLEAR: shadow_count = 0;
            default: ;
        endcase
        r.count     = shadow_count[CNT_W-1:0];
        r.empty_res = (shadow_count == 0);
        return r;
    endfunction

    function automatic string show_result(input list_result_t r);
        return $sformatf("st=%0d rd=%h fpos=%0d fnd=%0b cnt=%0d empty=%0b",
                         r.status, r.read_value, r.found_position, r.found,
                         r.count, r.empty_res);
    endfunction

    // Mostly pool values so searches hit, the rest fully random
    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 6)
            return value_pool[$urandom_range(0, POOL_SIZE-1)];
        return $urandom;
    endfunction

    // Mostly valid positions, sometimes past the end up to the field's top
    function automatic logic [CNT_W-1:0] pick_position(input logic [3:0] act);
        int first_bad;
        first_bad = (act == ACT_INSERT) ? shadow_count + 1 : shadow_count;
        if (first_bad == 0 || $urandom_range(0, 11) == 0)
            return CNT_W'($urandom_range(first_bad, 2**CNT_W - 1));
        return CNT_W'($urandom_range(0, first_bad - 1));
    endfunction

    // Offer one item in bursts with random gaps; predict it once taken
    task automatic send_item(input logic [3:0] act, input logic [CNT_W-1:0] pos,
                             input logic [VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_action     <= act;
        s_position   <= pos;
        s_item_value <= val;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(apply_action(act, pos, val));
    endtask

    // Field extremes, every action, bad positions, search misses, unused codes
    task automatic directed_edge_cases();
        send_item(ACT_CLEAR,     7'd0,   32'h0);
        send_item(ACT_READ,      7'd0,   32'h0);
        send_item(ACT_REMOVE,    7'd127, 32'hFFFF_FFFF);
        send_item(ACT_POP,       7'd64,  32'h0);
        send_item(ACT_FIND,      7'd0,   32'h1234_5678);
        send_item(ACT_CONTAINS,  7'd0,   32'h1234_5678);
        send_item(ACT_APPEND,    7'd127, 32'h0);
        send_item(ACT_APPEND,    7'd0,   32'hFFFF_FFFF);
        send_item(ACT_INSERT,    7'd0,   32'h0000_0005);
        send_item(ACT_INSERT,    7'd3,   32'hA5A5_A5A5);
        send_item(ACT_INSERT,    7'd5,   32'h5A5A_5A5A);
        send_item(ACT_READ,      7'd0,   32'h0);
        send_item(ACT_READ,      7'd3,   32'h0);
        send_item(ACT_READ,      7'd4,   32'h0);
        send_item(ACT_OVERWRITE, 7'd1,   32'h0000_0005);
        send_item(ACT_OVERWRITE, 7'd4,   32'hDEAD_BEEF);
        send_item(ACT_FIND,      7'd0,   32'h0000_0005);
        send_item(ACT_CONTAINS,  7'd0,   32'hA5A5_A5A5);
        send_item(ACT_FIND,      7'd0,   32'h0BAD_F00D);
        send_item(ACT_REMOVE,    7'd0,   32'h0);
        send_item(ACT_POP,       7'd2,   32'h0);
        send_item(4'hF,          7'd127, 32'hFFFF_FFFF);
        send_item(4'h9,          7'd0,   32'h0);
        send_item(ACT_CLEAR,     7'd127, 32'hFFFF_FFFF);
    endtask

    // Fill to DEPTH, hit the full and range checks at the top, then empty
    task automatic full_store();
        int k;
        send_item(ACT_CLEAR, 7'd0, 32'h0);
        for (k = 0; k < DEPTH; k++)
            send_item(ACT_APPEND, CNT_W'($urandom_range(0, 127)), pick_value());
        send_item(ACT_APPEND,   7'd0,  32'h1111_1111);
        send_item(ACT_INSERT,   7'd64, 32'h2222_2222);
        send_item(ACT_INSERT,   7'd65, 32'h3333_3333);
        send_item(ACT_INSERT,   7'd0,  32'h4444_4444);
        send_item(ACT_READ,     7'd63, 32'h0);
        send_item(ACT_READ,     7'd64, 32'h0);
        send_item(ACT_FIND,     7'd0,  shadow_entries[DEPTH-1]);
        send_item(ACT_POP,      7'd63, 32'h0);
        send_item(ACT_INSERT,   7'd0,  32'hFFFF_FFFF);
        send_item(ACT_CONTAINS, 7'd0,  32'hFFFF_FFFF);
        send_item(ACT_CLEAR,    7'd0,  32'h0);
    endtask

    // Store contents drift toward a moving fill target
    task automatic random_traffic(input int n_items);
        int                 k;
        int                 pick;
        int                 fill_target;
        logic [3:0]         act;
        logic [CNT_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        fill_target = $urandom_range(0, DEPTH);
        for (k = 0; k < n_items; k++) begin
            if (shadow_count == fill_target)
                fill_target = $urandom_range(0, DEPTH);
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                if (shadow_count < fill_target || (shadow_count == DEPTH && pick < 4))
                    act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
                else
                    act = $urandom_range(0, 1) ? ACT_REMOVE : ACT_POP;
            end else if (pick < 60) begin
                act = ACT_READ;
            end else if (pick < 71) begin
                act = ACT_OVERWRITE;
            end else if (pick < 82) begin
                act = ACT_FIND;
            end else if (pick < 95) begin
                act = ACT_CONTAINS;
            end else if (pick < 97) begin
                act = ACT_CLEAR;
            end else begin
                act = 4'($urandom_range(9, 15));
            end
            case (act)
                ACT_INSERT, ACT_READ, ACT_OVERWRITE, ACT_REMOVE, ACT_POP:
                    pos = pick_position(act);
                default: pos = CNT_W'($urandom_range(0, 2**CNT_W - 1));
            endcase
            if ((act == ACT_FIND || act == ACT_CONTAINS) && shadow_count > 0
                && $urandom_range(0, 1))
                val = shadow_entries[$urandom_range(0, shadow_count - 1)];
            else
                val = pick_value();
            send_item(act, pos, val);
        end
    endtask

    // Receiver holds off long enough for the block to fill and stall its input
    task automatic output_backpressure();
        hold_request = 1'b1;
        random_traffic(40);
    endtask

    // Receiver: changing stall patterns, plus the long hold-off on request
    initial begin
        m_ready    = 1'b0;
        rx_pattern = RX_ALWAYS;
        rx_left    = 0;
        hold_left  = 0;
        rx_phase   = 0;
    end

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                rx_left    = $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_pattern)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                default:   m_ready <= (rx_phase % 3 == 0);
            endcase
        end
    end

    // Compare each result item with the oldest prediction
    always @(posedge aclk) begin : result_check
        list_result_t got;
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_read_value, m_found_position, m_found, m_count, m_empty_res};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result item: %s", show_result(got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result mismatch: expected %s, got %s",
                                 show_result(want), show_result(got));
                end
            end
        end
    end

    // Watchdog on cycles with nothing moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACT_APPEND;
        s_position     = '0;
        s_item_value   = '0;
        hold_request   = 1'b0;
        burst_left     = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        shadow_count   = 0;
        foreach (shadow_entries[k])
            shadow_entries[k] = '0;
        foreach (value_pool[k])
            value_pool[k] = $urandom;
        value_pool[0] = '0;
        value_pool[1] = '1;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_edge_cases();
        full_store();
        output_backpressure();
        random_traffic(850);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ils_pkg.sv
hw/rtl/ils_cell.sv
hw/rtl/ils_collect.sv
hw/rtl/indexed_list_store.sv
dv/tb_indexed_list_store.sv
